### rtl/core/pbwfs_pkg.sv
// Shared types and codes for the protobuf wire field splitter.
package pbwfs_pkg;

	localparam int LEN_BITS_DEF = 32;

	// wire types
	localparam logic [2:0] WIRE_VARINT  = 3'd0;
	localparam logic [2:0] WIRE_FIXED64 = 3'd1;
	localparam logic [2:0] WIRE_LENDEL  = 3'd2;
	localparam logic [2:0] WIRE_FIXED32 = 3'd5;

	// byte roles
	localparam logic [1:0] ROLE_TAG     = 2'd0;
	localparam logic [1:0] ROLE_LENGTH  = 2'd1;
	localparam logic [1:0] ROLE_VALUE   = 2'd2;
	localparam logic [1:0] ROLE_DISCARD = 2'd3;

	// error codes
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_LONG  = 2'd1;
	localparam logic [1:0] ERR_TRUNC = 2'd2;
	localparam logic [1:0] ERR_WIRE  = 2'd3;

	localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

	typedef enum logic [1:0] {
		ABS_END  = 2'd0,
		ABS_MORE = 2'd1,
		ABS_LONG = 2'd2
	} absorb_status_t;

	typedef struct packed {
		logic [63:0]    acc;
		logic [3:0]     count;
		absorb_status_t status;
	} absorb_res_t;

endpackage

### rtl/core/protobuf_wire_field_splitter_unit.sv
// Top level of the protobuf wire field splitter: byte decoder and result register.
//
// Usage notes
// - Slave channel s_*: one message byte per request, s_tdata = data_byte,
//   s_tlast marks the final byte of a message.
// - Master channel m_*: exactly one result per input byte, in order.
//   m_tuser carries the byte role (tag, length prefix, value, discarded),
//   m_tlast echoes the message end flag, m_tdata the decoded fields.
// - The result is registered: it is valid in the cycle after the input byte is accepted.
// - Throughput: one byte per cycle while no result is held or m_tready is
//   high. The whole per-byte update (varint absorb, phase decode, length
//   saturation) sits between the parser state registers and the result
//   register; zigzag is formed from the registered raw value.
// - Stall: the result register holds while m_tready is low; s_tready drops
//   only while a result is held and not taken, so no byte is lost.
// - Reset (arst_n low): parser returns to the tag phase with empty
//   accumulator and counters; the result register empties. No clearing pass.
// - Errors (varint over 10 bytes, truncated message, unknown wire type) are
//   flagged once; later bytes of that message come out as discarded and the
//   byte after the final one starts a fresh message.
module protobuf_wire_field_splitter_unit #(
	parameter int LEN_BITS = pbwfs_pkg::LEN_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	input  logic         s_tlast,   // last_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [31:0] field_number, [34:32] wire_kind, [42:35] payload_byte,
	// [43] field_done, [107:44] varint_value, [171:108] zigzag_value,
	// [203:172] payload_length, [205:204] error_code, [207:206] zero
	output logic [207:0] m_tdata,
	output logic [1:0]   m_tuser,   // [1:0] byte_role
	output logic         m_tlast    // message_end
);

	typedef enum logic [4:0] {
		PH_TAG     = 5'b00001,
		PH_VARINT  = 5'b00010,
		PH_LENGTH  = 5'b00100,
		PH_PAYLOAD = 5'b01000,
		PH_DISCARD = 5'b10000
	} phase_t;

	localparam logic [63:0] LenMax = (LEN_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << LEN_BITS) - 64'd1);

	// parser state
	phase_t              phase_q;
	logic [63:0]         acc_q;
	logic [3:0]          cnt_q;
	logic [31:0]         fnum_q;
	logic [2:0]          wkind_q;
	logic [LEN_BITS-1:0] rem_q;

	// next state
	phase_t              phase_d;
	logic [63:0]         acc_d;
	logic [3:0]          cnt_d;
	logic [31:0]         fnum_d;
	logic [2:0]          wkind_d;
	logic [LEN_BITS-1:0] rem_d;

	// result of this byte
	logic [31:0] o_fn;
	logic [2:0]  o_wk;
	logic [1:0]  o_role;
	logic        o_done;
	logic [63:0] o_vv;
	logic [31:0] o_plen;
	logic [1:0]  o_err;
	logic        open;

	logic [63:0]         len_sat;
	logic [LEN_BITS-1:0] rem_dec;
	logic                accept;

	pbwfs_pkg::absorb_res_t ab;

	// result register
	logic        ovalid_q;
	logic [31:0] rfn_q;
	logic [2:0]  rwk_q;
	logic [1:0]  rrole_q;
	logic [7:0]  rbyte_q;
	logic        rdone_q;
	logic [63:0] rvv_q;
	logic [31:0] rplen_q;
	logic [1:0]  rerr_q;
	logic        rlast_q;

	pbwfs_varint_absorb u_absorb (
		.acc   (acc_q),
		.count (cnt_q),
		.data  (s_tdata),
		.res   (ab)
	);

	assign s_tready = !ovalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	assign len_sat = (ab.acc > LenMax) ? LenMax : ab.acc;
	assign rem_dec = (rem_q != '0) ? (rem_q - LEN_BITS'(1)) : rem_q;

	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		fnum_d  = fnum_q;
		wkind_d = wkind_q;
		rem_d   = rem_q;
		o_fn    = fnum_q;
		o_wk    = wkind_q;
		o_role  = pbwfs_pkg::ROLE_DISCARD;
		o_done  = 1'b0;
		o_vv    = '0;
		o_plen  = '0;
		o_err   = pbwfs_pkg::ERR_NONE;
		open    = 1'b0;

		case (phase_q)
			PH_TAG: begin
				o_role = pbwfs_pkg::ROLE_TAG;
				acc_d  = ab.acc;
				cnt_d  = ab.count;
				o_fn   = ab.acc[34:3];
				o_wk   = ab.acc[2:0];
				if (ab.status == pbwfs_pkg::ABS_LONG) begin
					o_err = pbwfs_pkg::ERR_LONG;
				end else if (ab.status == pbwfs_pkg::ABS_MORE) begin
					open = 1'b1;
				end else begin
					fnum_d  = ab.acc[34:3];
					wkind_d = ab.acc[2:0];
					acc_d   = '0;
					cnt_d   = '0;
					open    = 1'b1;
					case (ab.acc[2:0])
						pbwfs_pkg::WIRE_VARINT: begin
							phase_d = PH_VARINT;
						end
						pbwfs_pkg::WIRE_FIXED64: begin
							rem_d   = LEN_BITS'(8);
							phase_d = PH_PAYLOAD;
						end
						pbwfs_pkg::WIRE_FIXED32: begin
							rem_d   = LEN_BITS'(4);
							phase_d = PH_PAYLOAD;
						end
						pbwfs_pkg::WIRE_LENDEL: begin
							phase_d = PH_LENGTH;
						end
						default: begin
							o_err = pbwfs_pkg::ERR_WIRE;
						end
					endcase
				end
			end
			PH_VARINT: begin
				o_role = pbwfs_pkg::ROLE_VALUE;
				acc_d  = ab.acc;
				cnt_d  = ab.count;
				if (ab.status == pbwfs_pkg::ABS_LONG) begin
					o_err = pbwfs_pkg::ERR_LONG;
				end else if (ab.status == pbwfs_pkg::ABS_MORE) begin
					open = 1'b1;
				end else begin
					o_done  = 1'b1;
					o_vv    = ab.acc;
					acc_d   = '0;
					cnt_d   = '0;
					phase_d = PH_TAG;
				end
			end
			PH_LENGTH: begin
				o_role = pbwfs_pkg::ROLE_LENGTH;
				acc_d  = ab.acc;
				cnt_d  = ab.count;
				if (ab.status == pbwfs_pkg::ABS_LONG) begin
					o_err = pbwfs_pkg::ERR_LONG;
				end else if (ab.status == pbwfs_pkg::ABS_MORE) begin
					open = 1'b1;
				end else begin
					o_plen = (len_sat[63:32] != '0) ? 32'hFFFF_FFFF : len_sat[31:0];
					acc_d  = '0;
					cnt_d  = '0;
					if (len_sat == '0) begin
						o_done  = 1'b1;
						phase_d = PH_TAG;
					end else begin
						rem_d   = len_sat[LEN_BITS-1:0];
						phase_d = PH_PAYLOAD;
						open    = 1'b1;
					end
				end
			end
			PH_PAYLOAD: begin
				o_role = pbwfs_pkg::ROLE_VALUE;
				rem_d  = rem_dec;
				if (rem_dec == '0) begin
					o_done  = 1'b1;
					phase_d = PH_TAG;
				end else begin
					open = 1'b1;
				end
			end
			default: begin
				// discard rest of a failed message
				if (s_tlast) begin
					phase_d = PH_TAG;
					acc_d   = '0;
					cnt_d   = '0;
					rem_d   = '0;
				end
			end
		endcase

		if (o_err == pbwfs_pkg::ERR_NONE && open && s_tlast) begin
			o_err = pbwfs_pkg::ERR_TRUNC;
		end
		if (o_err != pbwfs_pkg::ERR_NONE) begin
			o_done  = 1'b0;
			o_vv    = '0;
			o_plen  = '0;
			acc_d   = '0;
			cnt_d   = '0;
			rem_d   = '0;
			phase_d = s_tlast ? PH_TAG : PH_DISCARD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			acc_q   <= '0;
			cnt_q   <= '0;
			fnum_q  <= '0;
			wkind_q <= '0;
			rem_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			fnum_q  <= fnum_d;
			wkind_q <= wkind_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (accept) begin
			ovalid_q <= 1'b1;
		end else if (m_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rfn_q   <= o_fn;
			rwk_q   <= o_wk;
			rrole_q <= o_role;
			rbyte_q <= s_tdata;
			rdone_q <= o_done;
			rvv_q   <= o_vv;
			rplen_q <= o_plen;
			rerr_q  <= o_err;
			rlast_q <= s_tlast;
		end
	end

	// zigzag on the registered raw value: (v >> 1) ^ -(v & 1)
	assign m_tvalid = ovalid_q;
	assign m_tdata  = {2'b00, rerr_q, rplen_q, ({1'b0, rvv_q[63:1]} ^ {64{rvv_q[0]}}),
		rvv_q, rdone_q, rbyte_q, rwk_q, rfn_q};
	assign m_tuser  = rrole_q;
	assign m_tlast  = rlast_q;

`ifndef NO_ASSERTIONS
	a_done_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(rdone_q && rerr_q != pbwfs_pkg::ERR_NONE))
		else $error("field done reported together with an error");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= pbwfs_pkg::VARINT_LAST_IDX)
		else $error("varint byte count out of range");

	a_err_discard: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && o_err != pbwfs_pkg::ERR_NONE && !s_tlast) |=> phase_q == PH_DISCARD)
		else $error("error did not enter discard phase");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without a held result");
`endif

endmodule

### rtl/core/pbwfs_varint_absorb.sv
// Adds one byte to the running varint and classifies its end.
module pbwfs_varint_absorb (
	input  logic [63:0]          acc,
	input  logic [3:0]           count,
	input  logic [7:0]           data,
	output pbwfs_pkg::absorb_res_t res
);

	logic [3:0] n;
	logic [5:0] sh;

	always_comb begin
		n = (count > pbwfs_pkg::VARINT_LAST_IDX) ? pbwfs_pkg::VARINT_LAST_IDX : count;
		sh = 6'(n) * 6'd7;
		res.acc = acc | ({57'd0, data[6:0]} << sh);
		res.count = count;
		if (!data[7]) begin
			res.status = pbwfs_pkg::ABS_END;
		end else if (n == pbwfs_pkg::VARINT_LAST_IDX) begin
			res.status = pbwfs_pkg::ABS_LONG;
		end else begin
			res.status = pbwfs_pkg::ABS_MORE;
			res.count = n + 4'd1;
		end
	end

endmodule
